>>> design/pvld_pkg.sv
package pvld_pkg;

  // Group header codes as they appear on the byte stream
  localparam logic [7:0] HDR_ONE     = 8'h01;
  localparam logic [7:0] HDR_TWO     = 8'h02;
  localparam logic [7:0] HDR_PAIRMAP = 8'h03;
  localparam logic [7:0] HDR_FOUR    = 8'h04;
  localparam logic [7:0] HDR_PIXMAP  = 8'h06;
  localparam logic [7:0] HDR_EIGHT   = 8'h08;
  localparam logic [7:0] HDR_SIXTEEN = 8'h10;

  // Pixels in one group, and width of a run length (1..16)
  localparam int GROUP_PIXELS = 16;
  localparam int RUN_W        = 5;

  // Parser state: waiting for a header, or inside a group of some format
  typedef enum logic [2:0] {
    FMT_HEADER,
    FMT_ONE,
    FMT_TWO,
    FMT_FOUR,
    FMT_EIGHT,
    FMT_SIXTEEN,
    FMT_PAIRMAP,
    FMT_PIXMAP
  } fmt_t;

  // One pixel run for the back end. A flat colour run uses map = 0 and
  // colour_zero. Bit k of the map (MSB first) picks colour_one for pixel k,
  // or for pixels 2k and 2k+1 when pair is set.
  typedef struct packed {
    logic [7:0]       colour_zero;
    logic [7:0]       colour_one;
    logic [7:0]       map;
    logic             pair;
    logic [RUN_W-1:0] count;
    logic             line_done;
  } cmd_t;

endpackage

>>> design/pvld_in_if.sv
interface pvld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       line_start;

  modport source (output valid, data_byte, line_start, input ready);
  modport sink   (input valid, data_byte, line_start, output ready);
endinterface

>>> design/pvld_out_if.sv
interface pvld_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       run_last;
  logic       line_last;

  modport source (output valid, pixel, run_last, line_last, input ready);
  modport sink   (input valid, pixel, run_last, line_last, output ready);
endinterface

>>> design/pvld_front.sv
module pvld_front #(
  parameter int LINE_PIXELS = 768
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          line_start,
  input  logic          q_full,
  output logic          q_push,
  output pvld_pkg::cmd_t q_cmd
);
  import pvld_pkg::*;

  localparam int PW = $clog2(LINE_PIXELS);
  localparam int RW = PW + 1;

  fmt_t          fmt, fmt_next;
  logic [2:0]    payload_index, payload_index_next;
  logic [7:0]    colour_zero, colour_zero_next;
  logic [7:0]    colour_one, colour_one_next;
  logic [PW-1:0] pixel_position, pixel_position_next;

  fmt_t          fmt_eff;
  logic [2:0]    idx_eff;
  logic [PW-1:0] pos_eff;
  logic [RUN_W-1:0] n;
  logic [7:0]    run_c0, run_map;
  logic          run_pair;
  logic [RW-1:0] remaining;
  logic          done;
  logic [RUN_W-1:0] emitted;
  logic          accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Start of line resynchronizes the parser before the byte is decoded
  always_comb begin
    fmt_eff = line_start ? FMT_HEADER : fmt;
    idx_eff = line_start ? 3'd0 : payload_index;
    pos_eff = line_start ? '0 : pixel_position;
  end

  // Classify the byte: state update and the pixel run it produces
  always_comb begin
    fmt_next           = fmt_eff;
    payload_index_next = idx_eff;
    colour_zero_next   = colour_zero;
    colour_one_next    = colour_one;
    n                  = '0;
    run_c0             = data_byte;
    run_map            = 8'h00;
    run_pair           = 1'b0;
    case (fmt_eff)
      FMT_HEADER: begin
        payload_index_next = 3'd0;
        case (data_byte)
          HDR_ONE:     fmt_next = FMT_ONE;
          HDR_TWO:     fmt_next = FMT_TWO;
          HDR_PAIRMAP: fmt_next = FMT_PAIRMAP;
          HDR_FOUR:    fmt_next = FMT_FOUR;
          HDR_PIXMAP:  fmt_next = FMT_PIXMAP;
          HDR_EIGHT:   fmt_next = FMT_EIGHT;
          HDR_SIXTEEN: fmt_next = FMT_SIXTEEN;
          default: begin
            // unknown header: a group of zero pixels
            n      = RUN_W'(GROUP_PIXELS);
            run_c0 = 8'h00;
          end
        endcase
      end
      FMT_PAIRMAP: begin
        if (idx_eff == 3'd0) begin
          colour_zero_next   = data_byte;
          payload_index_next = 3'd1;
        end else if (idx_eff == 3'd1) begin
          colour_one_next    = data_byte;
          payload_index_next = 3'd2;
        end else begin
          n        = RUN_W'(GROUP_PIXELS);
          run_c0   = colour_zero;
          run_map  = data_byte;
          run_pair = 1'b1;
        end
      end
      FMT_PIXMAP: begin
        logic [2:0] i;
        i = (idx_eff > 3'd5) ? 3'd0 : idx_eff;
        payload_index_next = i + 3'd1;
        if (i == 3'd0 || i == 3'd3) begin
          colour_zero_next = data_byte;
        end else if (i == 3'd1 || i == 3'd4) begin
          colour_one_next = data_byte;
        end else begin
          n       = RUN_W'(GROUP_PIXELS / 2);
          run_c0  = colour_zero;
          run_map = data_byte;
        end
      end
      FMT_ONE:     n = RUN_W'(16);
      FMT_TWO:     n = RUN_W'(8);
      FMT_FOUR:    n = RUN_W'(4);
      FMT_EIGHT:   n = RUN_W'(2);
      FMT_SIXTEEN: n = RUN_W'(1);
      default:     n = '0;
    endcase

    // Cut the run at the end of the line
    remaining = RW'(LINE_PIXELS) - RW'(pos_eff);
    done      = (RW'(n) >= remaining);
    emitted   = done ? remaining[RUN_W-1:0] : n;
    pixel_position_next = done ? '0 : (pos_eff + PW'(n));

    // Group closes on line end or a 16-pixel boundary
    if (n != '0 && (done || pixel_position_next[3:0] == 4'd0)) begin
      fmt_next           = FMT_HEADER;
      payload_index_next = 3'd0;
    end
  end

  always_comb begin
    q_push            = accept && (n != '0);
    q_cmd.colour_zero = run_c0;
    q_cmd.colour_one  = colour_one;
    q_cmd.map         = run_map;
    q_cmd.pair        = run_pair;
    q_cmd.count       = emitted;
    q_cmd.line_done   = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt            <= FMT_HEADER;
      payload_index  <= 3'd0;
      colour_zero    <= 8'h00;
      colour_one     <= 8'h00;
      pixel_position <= '0;
    end else if (accept) begin
      fmt            <= fmt_next;
      payload_index  <= payload_index_next;
      colour_zero    <= colour_zero_next;
      colour_one     <= colour_one_next;
      pixel_position <= pixel_position_next;
    end
  end

endmodule

>>> design/pvld_queue.sv
module pvld_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pvld_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output pvld_pkg::cmd_t head
);
  import pvld_pkg::*;

  // Two-entry run queue
  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full  = (fill == 2'd2);
  assign empty = (fill == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

>>> design/pvld_back.sv
module pvld_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  pvld_pkg::cmd_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     pixel,
  output logic           run_last,
  output logic           line_last
);
  import pvld_pkg::*;

  cmd_t       cur;
  logic       busy;
  logic [3:0] k;

  logic       advance;
  logic       last;
  logic [2:0] bit_idx;
  logic [7:0] pix_value;

  // Pixel k of the current run
  always_comb begin
    advance   = busy && (!out_valid || out_ready);
    last      = ({1'b0, k} + RUN_W'(1)) == cur.count;
    bit_idx   = cur.pair ? k[3:1] : k[2:0];
    pix_value = cur.map[3'd7 - bit_idx] ? cur.colour_one : cur.colour_zero;
    q_pop     = !q_empty && (!busy || (advance && last));
  end

  // Run sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      k    <= 4'd0;
    end else if (q_pop) begin
      busy <= 1'b1;
      k    <= 4'd0;
    end else if (advance) begin
      if (last) begin
        busy <= 1'b0;
        k    <= 4'd0;
      end else begin
        k <= k + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel     <= pix_value;
      run_last  <= last;
      line_last <= last && cur.line_done;
    end
  end

endmodule

>>> design/packed_video_line_decoder_top.sv
// Packed video line decoder.
// in_ch carries one byte of the packed line per beat (data_byte) with
// line_start set on the first byte of a line. out_ch carries one decoded
// pixel index per beat; run_last marks the last pixel produced by an input
// byte and line_last marks pixel LINE_PIXELS-1 of the line.
// Bytes that finish no pixels (known headers, colour bytes) produce no beats.
// The first pixel of a byte passes the run queue, the current-run register
// of the pixel path and the output register on its way to out_ch.
// Throughput: the pixel path emits one pixel per cycle while out_ch takes
// them, and a byte yields 1 to 16 pixels. The parser takes one byte per
// cycle while the two-entry run queue between parser and pixel path has
// room.
// Reset (rst, synchronous) empties the queue and output register and puts
// the parser at pixel 0, waiting for a group header.
// When out_ch stalls, the output register holds its pixel, the pixel path
// stops, and in_ch drops ready once the run queue is full.
module packed_video_line_decoder_top #(
  parameter int LINE_PIXELS = 768
) (
  input logic        clk,
  input logic        rst,
  pvld_in_if.sink    in_ch,
  pvld_out_if.source out_ch
);
  import pvld_pkg::*;

  cmd_t q_cmd;
  cmd_t q_head;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  pvld_front #(
    .LINE_PIXELS(LINE_PIXELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .data_byte  (in_ch.data_byte),
    .line_start (in_ch.line_start),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  pvld_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  pvld_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .pixel     (out_ch.pixel),
    .run_last  (out_ch.run_last),
    .line_last (out_ch.line_last)
  );

endmodule

>>> verif/packed_video_line_decoder_top_tb.sv
module packed_video_line_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pvld_pkg::*;

  localparam int LINE_PIXELS  = 768;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  // One decoded pixel beat as seen on out_ch
  typedef struct packed {
    logic [7:0] pixel;
    logic       run_last;
    logic       line_last;
  } pixel_beat_t;

  // Group shapes the stimulus can build
  typedef enum int {
    GRP_ONE,
    GRP_TWO,
    GRP_FOUR,
    GRP_EIGHT,
    GRP_SIXTEEN,
    GRP_PAIRMAP,
    GRP_PIXMAP,
    GRP_UNKNOWN
  } grp_kind_t;

  logic clk = 1'b0;
  logic rst;

  pvld_in_if  in_ch ();
  pvld_out_if out_ch ();

  packed_video_line_decoder_top #(
    .LINE_PIXELS(LINE_PIXELS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // Decoder state mirror
  fmt_t        grp_fmt;
  logic [2:0]  pay_idx;
  logic [7:0]  col_zero;
  logic [7:0]  col_one;
  int          pix_pos;
  pixel_beat_t byte_pixels[$];
  bit          line_wrapped;
  pixel_beat_t expected_pixels[$];

  // Traffic shaping and bookkeeping
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int bytes_sent     = 0;
  int pixels_checked = 0;
  int lines_seen     = 0;
  int bad_beats      = 0;

  function automatic void clear_decoder_state();
    grp_fmt  = FMT_HEADER;
    pay_idx  = '0;
    col_zero = '0;
    col_one  = '0;
    pix_pos  = 0;
  endfunction

  // One pixel; a byte never yields more than a group, nor crosses the line end
  function automatic void emit_pixel(logic [7:0] v);
    pixel_beat_t beat;
    if (line_wrapped || byte_pixels.size() >= GROUP_PIXELS) return;
    beat.pixel     = v;
    beat.run_last  = 1'b0;
    beat.line_last = (pix_pos + 1 >= LINE_PIXELS);
    byte_pixels.push_back(beat);
    pix_pos++;
    if (pix_pos >= LINE_PIXELS) begin
      pix_pos      = 0;
      line_wrapped = 1'b1;
    end
  endfunction

  // Bitmap expansion, MSB first, each bit covering 'times' pixels
  function automatic void emit_bitmap(logic [7:0] map, int times);
    for (int k = 7; k >= 0; k--) begin
      for (int t = 0; t < times; t++) emit_pixel(map[k] ? col_one : col_zero);
    end
  endfunction

  function automatic int fill_repeat(fmt_t f);
    case (f)
      FMT_ONE:     return 16;
      FMT_TWO:     return 8;
      FMT_FOUR:    return 4;
      FMT_EIGHT:   return 2;
      FMT_SIXTEEN: return 1;
      default:     return 0;
    endcase
  endfunction

  // Decode one accepted byte and queue the pixels it produces
  function automatic void decode_byte(logic [7:0] b, logic ls);
    int reps;
    byte_pixels.delete();
    line_wrapped = 1'b0;
    if (ls) begin
      grp_fmt = FMT_HEADER;
      pay_idx = '0;
      pix_pos = 0;
    end
    case (grp_fmt)
      FMT_HEADER: begin
        pay_idx = '0;
        case (b)
          HDR_ONE:     grp_fmt = FMT_ONE;
          HDR_TWO:     grp_fmt = FMT_TWO;
          HDR_PAIRMAP: grp_fmt = FMT_PAIRMAP;
          HDR_FOUR:    grp_fmt = FMT_FOUR;
          HDR_PIXMAP:  grp_fmt = FMT_PIXMAP;
          HDR_EIGHT:   grp_fmt = FMT_EIGHT;
          HDR_SIXTEEN: grp_fmt = FMT_SIXTEEN;
          default: begin
            for (int i = 0; i < GROUP_PIXELS; i++) emit_pixel(8'h00);
          end
        endcase
      end
      FMT_PAIRMAP: begin
        if (pay_idx == 3'd0) begin
          col_zero = b;
          pay_idx  = 3'd1;
        end else if (pay_idx == 3'd1) begin
          col_one = b;
          pay_idx = 3'd2;
        end else begin
          emit_bitmap(b, 2);
        end
      end
      FMT_PIXMAP: begin
        if (pay_idx > 3'd5) pay_idx = '0;
        if (pay_idx == 3'd0 || pay_idx == 3'd3) col_zero = b;
        else if (pay_idx == 3'd1 || pay_idx == 3'd4) col_one = b;
        else emit_bitmap(b, 1);
        pay_idx = pay_idx + 3'd1;
      end
      default: begin
        reps = fill_repeat(grp_fmt);
        for (int i = 0; i < reps; i++) emit_pixel(b);
      end
    endcase
    if (byte_pixels.size() > 0) begin
      // group or line finished: next byte is a header
      if (line_wrapped || (pix_pos % GROUP_PIXELS) == 0) begin
        grp_fmt = FMT_HEADER;
        pay_idx = '0;
      end
      byte_pixels[byte_pixels.size() - 1].run_last = 1'b1;
      foreach (byte_pixels[i]) expected_pixels.push_back(byte_pixels[i]);
    end
  endfunction

  // Output side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare every accepted pixel beat with the oldest expected one
  always @(posedge clk) begin
    pixel_beat_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_pixels.size() == 0) begin
        bad_beats++;
        if (bad_beats <= MAX_REPORTS)
          $display("%0t: unexpected beat pixel=%02h run_last=%b line_last=%b",
                   $realtime, out_ch.pixel, out_ch.run_last, out_ch.line_last);
      end else begin
        want = expected_pixels.pop_front();
        if (out_ch.pixel !== want.pixel || out_ch.run_last !== want.run_last ||
            out_ch.line_last !== want.line_last) begin
          bad_beats++;
          if (bad_beats <= MAX_REPORTS)
            $display("%0t: mismatch exp pixel=%02h run_last=%b line_last=%b, got %02h %b %b",
                     $realtime, want.pixel, want.run_last, want.line_last,
                     out_ch.pixel, out_ch.run_last, out_ch.line_last);
        end
      end
      pixels_checked++;
      if (out_ch.line_last === 1'b1) lines_seen++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still pending",
               cycle_count, expected_pixels.size());
      $display("packed_video_line_decoder_top test failed");
      $finish;
    end
  end

  // Offer one byte, wait for the beat, then predict its pixels
  task automatic send_byte(input logic [7:0] b, input logic ls);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.line_start <= ls;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    decode_byte(b, ls);
    bytes_sent++;
  endtask

  function automatic logic [7:0] unknown_header();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b inside {HDR_ONE, HDR_TWO, HDR_PAIRMAP, HDR_FOUR,
                         HDR_PIXMAP, HDR_EIGHT, HDR_SIXTEEN});
    return b;
  endfunction

  // Header followed by its payload bytes with random content
  task automatic send_group(input grp_kind_t kind, input logic ls);
    logic [7:0] hdr;
    int         n;
    case (kind)
      GRP_ONE:     begin hdr = HDR_ONE;     n = 1;  end
      GRP_TWO:     begin hdr = HDR_TWO;     n = 2;  end
      GRP_FOUR:    begin hdr = HDR_FOUR;    n = 4;  end
      GRP_EIGHT:   begin hdr = HDR_EIGHT;   n = 8;  end
      GRP_SIXTEEN: begin hdr = HDR_SIXTEEN; n = 16; end
      GRP_PAIRMAP: begin hdr = HDR_PAIRMAP; n = 3;  end
      GRP_PIXMAP:  begin hdr = HDR_PIXMAP;  n = 6;  end
      default:     begin hdr = unknown_header(); n = 0; end
    endcase
    send_byte(hdr, ls);
    for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  function automatic grp_kind_t random_group_kind();
    case ($urandom_range(15))
      0, 1, 2:    return GRP_ONE;
      3, 4:       return GRP_TWO;
      5, 6:       return GRP_FOUR;
      7:          return GRP_EIGHT;
      8:          return GRP_SIXTEEN;
      9, 10:      return GRP_PAIRMAP;
      11, 12:     return GRP_PIXMAP;
      default:    return GRP_UNKNOWN;
    endcase
  endfunction

  // Formats one, two, four, pairmap and pixmap once each, with fixed bytes
  task automatic test_each_format();
    send_byte(HDR_ONE, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(HDR_TWO, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(HDR_FOUR, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(HDR_PAIRMAP, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(HDR_PIXMAP, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'hCC, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  // Unrecognized headers give a zero group straight away
  task automatic test_unknown_header();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
  endtask

  // line_start in the middle of a group drops it
  task automatic test_line_start_resync();
    send_byte(HDR_EIGHT, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(HDR_ONE, 1'b1);
    send_byte(8'hC3, 1'b0);
  endtask

  // Fill a whole line with short groups, then keep going with no line_start
  task automatic test_line_wrap();
    for (int g = 0; g < LINE_PIXELS / GROUP_PIXELS; g++)
      send_group($urandom_range(1) ? GRP_ONE : GRP_UNKNOWN, g == 0);
    send_group(GRP_PAIRMAP, 1'b0);
  endtask

  // Mostly well-formed groups, some stray bytes and early line starts
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_bytes);
    int target;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(15) == 0)
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      else
        send_group(random_group_kind(), $urandom_range(9) == 0);
    end
  endtask

  // Output held off while fill groups keep coming: the input must stall
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_token++;
    for (int g = 0; g < 12; g++) send_group(GRP_ONE, g == 0);
  endtask

  task automatic drain_pixels();
    in_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.line_start = 1'b0;
    out_ch.ready     = 1'b0;
    clear_decoder_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_each_format();
    test_unknown_header();
    test_line_start_resync();
    test_line_wrap();
    test_random_traffic(0, 0, 90);
    test_random_traffic(84, 0, 90);
    test_random_traffic(0, 84, 90);
    test_random_traffic(15, 15, 90);
    test_backpressure();
    test_random_traffic(0, 0, 20);
    drain_pixels();

    if (expected_pixels.size() != 0) bad_beats++;
    $display("Sent %0d bytes: all group formats, unknown headers, resyncs, line wraps.",
             bytes_sent);
    $display("Checked %0d pixels over %0d line ends, with idle, stall and hold-off phases.",
             pixels_checked, lines_seen);
    if (bad_beats == 0)
      $display("packed_video_line_decoder_top test passed");
    else
      $display("packed_video_line_decoder_top test failed");
    $finish;
  end

endmodule

>>> files.f
design/pvld_pkg.sv
design/pvld_in_if.sv
design/pvld_out_if.sv
design/pvld_front.sv
design/pvld_queue.sv
design/pvld_back.sv
design/packed_video_line_decoder_top.sv
verif/packed_video_line_decoder_top_tb.sv
